### rtl/ihl_pkg.sv
// Shared constants, codes and request types of the Intel HEX image loader.
`timescale 1ns / 1ps
`default_nettype none

package ihl_pkg;

    // Image geometry
    localparam int PAGE_BYTES   = 64;
    localparam int PAGE_COUNT   = 128;
    localparam int BOOT_BYTES   = 1024;
    localparam int RECORD_BYTES = 256;

    localparam int IMAGE_BYTES  = PAGE_COUNT * PAGE_BYTES;
    localparam int IMG_AW       = $clog2(IMAGE_BYTES);
    localparam int PG_AW        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int BUF_AW       = $clog2(RECORD_BYTES);
    localparam int RANGE_LIMIT  = IMAGE_BYTES - BOOT_BYTES;

    // Page number is address / (PAGE_BYTES - 3), done by reciprocal multiply
    localparam int     PAGE_DIV  = PAGE_BYTES - 3;
    localparam longint DIV_SCALE = 64'h0000_0001_0000_0000;
    localparam longint DIV_RECIP = DIV_SCALE / PAGE_DIV;

    localparam logic [9:0] COUNT_MAX   = 10'd1023;
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Record types
    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;

    // Text characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF_HEX = 8'h66;

    typedef enum logic [1:0] {
        ACT_CHAR,
        ACT_READ_IMAGE,
        ACT_READ_DIRTY,
        ACT_RESTART
    } action_t;

    typedef enum logic [2:0] {
        ST_PARSING,
        ST_DONE_OK,
        ST_ERR_FORMAT,
        ST_ERR_LENGTH,
        ST_ERR_CHECKSUM,
        ST_ERR_RANGE,
        ST_ERR_NO_END
    } parse_status_t;

    // Flash image port: one access per cycle
    typedef struct packed {
        logic              we;
        logic              re;
        logic [IMG_AW-1:0] addr;
        logic [7:0]        wdata;
    } img_req_t;

    // Record buffer port: one write and one read per cycle
    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } buf_req_t;

endpackage

`default_nettype wire

### rtl/ihl_image_mem.sv
// Flash image memory with erase sweep after reset and registered read.
`timescale 1ns / 1ps
`default_nettype none

module ihl_image_mem (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ihl_pkg::img_req_t req,
    output logic [7:0]            rdata,
    output logic                  clearing
);

    logic [7:0]                 image_ram [ihl_pkg::IMAGE_BYTES];
    logic [7:0]                 rdata_reg;
    logic                       clr_busy_reg;
    logic [ihl_pkg::IMG_AW-1:0] clr_addr_reg;

    localparam logic [ihl_pkg::IMG_AW-1:0] LAST_ADDR =
        ihl_pkg::IMG_AW'(ihl_pkg::IMAGE_BYTES - 1);

    // Erase sweep: one byte per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
                clr_busy_reg <= 1'b0;
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Storage array
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            image_ram[clr_addr_reg] <= ihl_pkg::ERASED_BYTE;
        else if (req.we)
            image_ram[req.addr] <= req.wdata;
        if (req.re)
            rdata_reg <= image_ram[req.addr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_busy_reg;

endmodule

`default_nettype wire

### rtl/ihl_rec_buf.sv
// Record data buffer: bytes of the current line, read back for the image copy.
`timescale 1ns / 1ps
`default_nettype none

module ihl_rec_buf (
    input  wire logic             clk,
    input  wire ihl_pkg::buf_req_t req,
    output logic [7:0]            rdata
);

    logic [7:0] rec_ram [ihl_pkg::RECORD_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
            rec_ram[req.waddr] <= req.wdata;
        if (req.re)
            rdata_reg <= rec_ram[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/ihl_page_div.sv
// Two-stage divide of the record address by the page divisor.
`timescale 1ns / 1ps
`default_nettype none

module ihl_page_div (
    input  wire logic        clk,
    input  wire logic [15:0] address,
    output logic [15:0]      page
);

    localparam logic [31:0] RECIP = 32'(ihl_pkg::DIV_RECIP);
    localparam logic [16:0] DIV17 = 17'(ihl_pkg::PAGE_DIV);
    localparam logic [25:0] DIV26 = 26'(ihl_pkg::PAGE_DIV);

    logic [47:0] prod;
    logic [15:0] q0_reg;
    logic [15:0] addr1_reg;
    logic [25:0] back;
    logic [16:0] rem;
    logic [15:0] page_reg;

    // Stage 1: estimate, low by at most one
    assign prod = {32'd0, address} * {16'd0, RECIP};

    always_ff @(posedge clk)
    begin
        q0_reg    <= prod[47:32];
        addr1_reg <= address;
    end

    // Stage 2: remainder check and correction
    assign back = {10'd0, q0_reg} * DIV26;
    assign rem  = {1'b0, addr1_reg} - back[16:0];

    always_ff @(posedge clk)
    begin
        if (rem >= DIV17)
            page_reg <= q0_reg + 16'd1;
        else
            page_reg <= q0_reg;
    end

    assign page = page_reg;

endmodule

`default_nettype wire

### rtl/intel_hex_image_loader_core.sv
// Top level: Intel HEX record parser, dirty-page flags and image copy sequencer.
`timescale 1ns / 1ps
`default_nettype none

//  Channel  | Handshake           | Payload
//  ---------+---------------------+--------------------------------------------
//  input    | in_valid, in_ready  | action, character, end_of_text, read_index
//  output   | out_valid, out_ready| status, read_data
//
//  A character passes S_EXEC while parsing, an in-range image read S_RD_IMG; a dirty
//  read or a restart goes straight to S_RESULT. A line end adds S_FIN_DIV, S_FIN_CORR,
//  S_FIN_PAGE and S_FIN_END (a short header skips the middle two), plus S_COPY for an
//  accepted data record (one buffer read per cycle). After reset an erase sweep writes
//  0xFF over all IMAGE_BYTES bytes while in_ready stays low. A waiting result holds in
//  the output register; the next transaction is still taken and parked until it drains.

module intel_hex_image_loader_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  character,
    input  wire logic        end_of_text,
    input  wire logic [12:0] read_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [7:0]       read_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RD_IMG,
        S_FIN_DIV,
        S_FIN_CORR,
        S_FIN_PAGE,
        S_COPY,
        S_FIN_END,
        S_RESULT
    } state_t;

    state_t                         state_reg;
    ihl_pkg::parse_status_t         status_reg;
    logic [7:0]                     char_reg;
    logic                           eot_reg;
    logic [7:0]                     rec_len_reg;
    logic [15:0]                    rec_addr_reg;
    logic [7:0]                     rec_type_reg;
    logic [7:0]                     csum_reg;
    logic [9:0]                     dcount_reg;
    logic [3:0]                     hi_nib_reg;
    logic [ihl_pkg::PAGE_COUNT-1:0] dirty_reg;
    logic [7:0]                     data_reg;
    logic [7:0]                     copy_cnt_reg;
    logic                           wr_pend_reg;
    logic [16:0]                    wr_addr_reg;
    logic                           out_valid_reg;
    ihl_pkg::parse_status_t         out_status_reg;
    logic [7:0]                     out_data_reg;

    ihl_pkg::img_req_t img_req;
    ihl_pkg::buf_req_t buf_req;
    logic [7:0]        img_rdata;
    logic [7:0]        buf_rdata;
    logic              clearing;
    logic [15:0]       page_q;

    logic              accept;
    logic              img_idx_ok;
    logic              dirty_idx_ok;
    logic              hex_ok;
    logic [3:0]        hex_val;
    logic              is_cr;
    logic              is_lf;
    logic              fmt_err;
    logic              colon_step;
    logic              digit_step;
    logic [9:0]        dc_m1;
    logic [8:0]        byte_idx;
    logic [8:0]        buf_idx;
    logic [7:0]        byte_val;
    logic [9:0]        dc_inc;
    logic [9:0]        ex_dc;
    logic              ex_finish;
    logic              len_bad;
    logic              range_bad;
    logic [16:0]       end_addr;
    logic              copy_more;
    logic              copy_go;

    // Memory and divider units
    ihl_image_mem u_image (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (img_req),
        .rdata    (img_rdata),
        .clearing (clearing)
    );

    ihl_rec_buf u_buf (
        .clk   (clk),
        .req   (buf_req),
        .rdata (buf_rdata)
    );

    ihl_page_div u_div (
        .clk     (clk),
        .address (rec_addr_reg),
        .page    (page_q)
    );

    assign in_ready     = (state_reg == S_IDLE) && !clearing;
    assign accept       = in_valid && in_ready;
    assign img_idx_ok   = int'(read_index) < ihl_pkg::IMAGE_BYTES;
    assign dirty_idx_ok = int'(read_index) < ihl_pkg::PAGE_COUNT;

    // Hex digit decode
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (char_reg inside {[ihl_pkg::CHAR_0:ihl_pkg::CHAR_9]})
            hex_val = 4'(char_reg - ihl_pkg::CHAR_0);
        else if (char_reg inside {[ihl_pkg::CHAR_UA:ihl_pkg::CHAR_UF]})
            hex_val = 4'(char_reg - ihl_pkg::CHAR_UA + 8'd10);
        else if (char_reg inside {[ihl_pkg::CHAR_LA:ihl_pkg::CHAR_LF_HEX]})
            hex_val = 4'(char_reg - ihl_pkg::CHAR_LA + 8'd10);
        else
            hex_ok = 1'b0;
    end

    // One character step of the line parser
    assign is_cr      = (char_reg == ihl_pkg::CHAR_CR);
    assign is_lf      = (char_reg == ihl_pkg::CHAR_LF);
    assign colon_step = !is_cr && !is_lf && (dcount_reg == 10'd0)
                        && (char_reg == ihl_pkg::CHAR_COLON);
    assign digit_step = !is_cr && !is_lf && (dcount_reg != 10'd0) && hex_ok;
    assign fmt_err    = !is_cr && !is_lf &&
                        (((dcount_reg == 10'd0) && (char_reg != ihl_pkg::CHAR_COLON))
                         || ((dcount_reg != 10'd0) && !hex_ok));
    assign dc_m1      = dcount_reg - 10'd1;
    assign byte_idx   = dc_m1[9:1];
    assign buf_idx    = byte_idx - 9'd4;
    assign byte_val   = {hi_nib_reg, hex_val};
    assign dc_inc     = (dcount_reg < ihl_pkg::COUNT_MAX) ? dcount_reg + 10'd1 : dcount_reg;
    assign ex_dc      = colon_step ? 10'd1 : (digit_step ? dc_inc : dcount_reg);
    assign ex_finish  = (is_lf && (dcount_reg != 10'd0))
                        || (eot_reg && !fmt_err && (ex_dc != 10'd0));

    // Data record checks
    assign len_bad   = ({1'b0, dc_m1} != (11'({rec_len_reg, 1'b0}) + 11'd10))
                       || (int'(rec_len_reg) > ihl_pkg::RECORD_BYTES);
    assign end_addr  = {1'b0, rec_addr_reg} + {9'd0, rec_len_reg};
    assign range_bad = int'(end_addr) > ihl_pkg::RANGE_LIMIT;
    assign copy_more = (copy_cnt_reg != rec_len_reg);
    assign copy_go   = (rec_type_reg == ihl_pkg::REC_DATA) && !len_bad
                       && (csum_reg == 8'd0) && !range_bad && (rec_len_reg != 8'd0);

    // Record buffer port
    always_comb
    begin
        buf_req.we    = (state_reg == S_EXEC) && digit_step && dc_m1[0]
                        && (byte_idx >= 9'd4)
                        && (int'(buf_idx) < ihl_pkg::RECORD_BYTES);
        buf_req.waddr = ihl_pkg::BUF_AW'(buf_idx);
        buf_req.wdata = byte_val;
        buf_req.re    = (state_reg == S_COPY) && copy_more;
        buf_req.raddr = ihl_pkg::BUF_AW'(copy_cnt_reg);
    end

    // Flash image port: copy writes, read on accepted image read
    always_comb
    begin
        img_req.we    = wr_pend_reg && (int'(wr_addr_reg) < ihl_pkg::IMAGE_BYTES);
        img_req.re    = accept && (action == ihl_pkg::ACT_READ_IMAGE) && img_idx_ok;
        img_req.wdata = buf_rdata;
        if (wr_pend_reg)
            img_req.addr = ihl_pkg::IMG_AW'(wr_addr_reg);
        else
            img_req.addr = ihl_pkg::IMG_AW'(read_index);
    end

    // Sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            status_reg     <= ihl_pkg::ST_PARSING;
            char_reg       <= '0;
            eot_reg        <= 1'b0;
            rec_len_reg    <= '0;
            rec_addr_reg   <= '0;
            rec_type_reg   <= '0;
            csum_reg       <= '0;
            dcount_reg     <= '0;
            hi_nib_reg     <= '0;
            dirty_reg      <= '0;
            data_reg       <= '0;
            copy_cnt_reg   <= '0;
            wr_pend_reg    <= 1'b0;
            wr_addr_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ihl_pkg::ST_PARSING;
            out_data_reg   <= '0;
        end
        else
        begin
            // image write follows the buffer read in the next cycle
            wr_pend_reg <= (state_reg == S_COPY) && copy_more;

            // output valid: load from the result state, drop on handshake
            if ((state_reg == S_RESULT) && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        char_reg <= character;
                        eot_reg  <= end_of_text;
                        case (action)
                            ihl_pkg::ACT_CHAR:
                            begin
                                data_reg <= 8'd0;
                                if (status_reg == ihl_pkg::ST_PARSING)
                                    state_reg <= S_EXEC;
                                else
                                    state_reg <= S_RESULT;
                            end
                            ihl_pkg::ACT_READ_IMAGE:
                            begin
                                data_reg <= 8'd0;
                                if (img_idx_ok)
                                    state_reg <= S_RD_IMG;
                                else
                                    state_reg <= S_RESULT;
                            end
                            ihl_pkg::ACT_READ_DIRTY:
                            begin
                                data_reg <= dirty_idx_ok
                                    ? {7'd0, dirty_reg[ihl_pkg::PG_AW'(read_index)]}
                                    : 8'd0;
                                state_reg <= S_RESULT;
                            end
                            default:
                            begin
                                // restart: status, line state and dirty flags
                                data_reg     <= 8'd0;
                                status_reg   <= ihl_pkg::ST_PARSING;
                                rec_len_reg  <= '0;
                                rec_addr_reg <= '0;
                                rec_type_reg <= '0;
                                csum_reg     <= '0;
                                dcount_reg   <= '0;
                                hi_nib_reg   <= '0;
                                dirty_reg    <= '0;
                                state_reg    <= S_RESULT;
                            end
                        endcase
                    end
                end

                S_EXEC:
                begin
                    if (fmt_err)
                        status_reg <= ihl_pkg::ST_ERR_FORMAT;
                    dcount_reg <= ex_dc;
                    if (digit_step)
                    begin
                        if (!dc_m1[0])
                            hi_nib_reg <= hex_val;
                        else
                        begin
                            csum_reg <= csum_reg + byte_val;
                            case (byte_idx)
                                9'd0:    rec_len_reg <= byte_val;
                                9'd1:    rec_addr_reg[15:8] <= byte_val;
                                9'd2:    rec_addr_reg[7:0] <= byte_val;
                                9'd3:    rec_type_reg <= byte_val;
                                default: ;
                            endcase
                        end
                    end
                    if (ex_finish)
                        state_reg <= S_FIN_DIV;
                    else
                    begin
                        if (eot_reg && !fmt_err)
                            status_reg <= ihl_pkg::ST_ERR_NO_END;
                        state_reg <= S_RESULT;
                    end
                end

                S_RD_IMG:
                begin
                    data_reg  <= img_rdata;
                    state_reg <= S_RESULT;
                end

                S_FIN_DIV:
                begin
                    // short header: fewer than 8 digits after the colon
                    if (dc_m1 < 10'd8)
                    begin
                        status_reg <= ihl_pkg::ST_ERR_LENGTH;
                        state_reg  <= S_FIN_END;
                    end
                    else
                        state_reg <= S_FIN_CORR;
                end

                S_FIN_CORR:
                begin
                    state_reg <= S_FIN_PAGE;
                end

                S_FIN_PAGE:
                begin
                    if (int'(page_q) < ihl_pkg::PAGE_COUNT)
                        dirty_reg[ihl_pkg::PG_AW'(page_q)] <= 1'b1;
                    if (copy_go)
                    begin
                        copy_cnt_reg <= '0;
                        state_reg    <= S_COPY;
                    end
                    else
                        state_reg <= S_FIN_END;
                    case (rec_type_reg)
                        ihl_pkg::REC_DATA:
                        begin
                            if (len_bad)
                                status_reg <= ihl_pkg::ST_ERR_LENGTH;
                            else if (csum_reg != 8'd0)
                                status_reg <= ihl_pkg::ST_ERR_CHECKSUM;
                            else if (range_bad)
                                status_reg <= ihl_pkg::ST_ERR_RANGE;
                        end
                        ihl_pkg::REC_EOF:
                            status_reg <= ihl_pkg::ST_DONE_OK;
                        default: ;
                    endcase
                end

                S_COPY:
                begin
                    // buffer read now, image write next cycle
                    wr_addr_reg <= {1'b0, rec_addr_reg} + {9'd0, copy_cnt_reg};
                    if (copy_more)
                        copy_cnt_reg <= copy_cnt_reg + 8'd1;
                    else
                        state_reg <= S_FIN_END;
                end

                S_FIN_END:
                begin
                    rec_len_reg  <= '0;
                    rec_addr_reg <= '0;
                    rec_type_reg <= '0;
                    csum_reg     <= '0;
                    dcount_reg   <= '0;
                    hi_nib_reg   <= '0;
                    if (eot_reg && (status_reg == ihl_pkg::ST_PARSING))
                        status_reg <= ihl_pkg::ST_ERR_NO_END;
                    state_reg <= S_RESULT;
                end

                S_RESULT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_status_reg <= status_reg;
                        out_data_reg   <= data_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign read_data = out_data_reg;

endmodule

`default_nettype wire
